// ===== hdl/lswc_pkg.sv =====
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared types, constants and helpers for the line segment window clipper.
// ----------------------------------------------------------------------------
package lswc_pkg;

    localparam int COORD_W     = 16;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int DIV_RADIX_B = 2;
    localparam int DIV_CYCLES  = PROD_W / DIV_RADIX_B;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
    localparam int MOVE_LIMIT  = 4;
    localparam int MOVE_W      = 3;
    localparam int CFG_IDX_W   = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        mag_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic [3:0]                code_t;

    localparam code_t CODE_LEFT   = 4'd1;
    localparam code_t CODE_RIGHT  = 4'd2;
    localparam code_t CODE_BOTTOM = 4'd4;
    localparam code_t CODE_TOP    = 4'd8;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam coord_t WIN_LEFT_RST   = COORD_W'(4000);
    localparam coord_t WIN_TOP_RST    = COORD_W'(2400);
    localparam coord_t WIN_RIGHT_RST  = COORD_W'(8800);
    localparam coord_t WIN_BOTTOM_RST = COORD_W'(7200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_BOTTOM = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } window_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_step;
        logic update;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic all_inside;
        logic reject_now;
        logic out_free;
    } status_t;

    function automatic code_t region(coord_t x, coord_t y, window_t w);
        code_t c;
        c = '0;
        if (x < w.left) begin
            c = c | CODE_LEFT;
        end else if (x > w.right) begin
            c = c | CODE_RIGHT;
        end
        if (y > w.bottom) begin
            c = c | CODE_BOTTOM;
        end else if (y < w.top) begin
            c = c | CODE_TOP;
        end
        return c;
    endfunction

endpackage

// ===== hdl/line_segment_window_clip.sv =====
// ----------------------------------------------------------------------------
// line_segment_window_clip
// Cohen-Sutherland clipping of one segment against a configurable window.
// ----------------------------------------------------------------------------
// One segment request is processed at a time. A request is trivially accepted
// or rejected, or first takes clip moves (at most four moves). Each move is
// bound by the shared radix-4 divider, which works on the 32-bit intersection
// product. The result sits in an output register; the next request is taken as
// soon as the current one has been handed to that register. Window registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only while
// no request is in flight, as the block itself does not enforce this.
module line_segment_window_clip import lswc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coord_t               cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  coord_t               s_start_x,
    input  coord_t               s_start_y,
    input  coord_t               s_end_x,
    input  coord_t               s_end_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_visible,
    output coord_t               m_clipped_start_x,
    output coord_t               m_clipped_start_y,
    output coord_t               m_clipped_end_x,
    output coord_t               m_clipped_end_y
);

    window_t win_reg;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= WIN_LEFT_RST;
            win_reg.top    <= WIN_TOP_RST;
            win_reg.right  <= WIN_RIGHT_RST;
            win_reg.bottom <= WIN_BOTTOM_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LEFT:   win_reg.left   <= cfg_wdata;
                CFG_TOP:    win_reg.top    <= cfg_wdata;
                CFG_RIGHT:  win_reg.right  <= cfg_wdata;
                CFG_BOTTOM: win_reg.bottom <= cfg_wdata;
                default:    win_reg        <= win_reg;
            endcase
        end
    end

    lswc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lswc_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .win               (win_reg),
        .s_start_x         (s_start_x),
        .s_start_y         (s_start_y),
        .s_end_x           (s_end_x),
        .s_end_y           (s_end_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_visible         (m_visible),
        .m_clipped_start_x (m_clipped_start_x),
        .m_clipped_start_y (m_clipped_start_y),
        .m_clipped_end_x   (m_clipped_end_x),
        .m_clipped_end_y   (m_clipped_end_y)
    );

    // rejected requests carry zero endpoints
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_visible) |-> (m_clipped_start_x == '0 && m_clipped_start_y == '0
            && m_clipped_end_x == '0 && m_clipped_end_y == '0))
        else $error("rejected request with nonzero endpoints");

    // accepted endpoints lie inside the window
    a_inside_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_visible) |->
            (m_clipped_start_x >= win_reg.left && m_clipped_start_x <= win_reg.right
             && m_clipped_end_x >= win_reg.left && m_clipped_end_x <= win_reg.right))
        else $error("accepted endpoint outside window in x");

    a_inside_y: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_visible) |->
            (m_clipped_start_y >= win_reg.top && m_clipped_start_y <= win_reg.bottom
             && m_clipped_end_y >= win_reg.top && m_clipped_end_y <= win_reg.bottom))
        else $error("accepted endpoint outside window in y");

    // one request in flight
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");

endmodule

// ===== hdl/lswc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lswc_ctrl
// Sequencer: accept/reject tests, clip moves, divider steps, result hand-off.
// ----------------------------------------------------------------------------
module lswc_ctrl import lswc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [MOVE_W-1:0]    moves_reg, moves_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 check_done;
    logic                 div_last;

    assign check_done = status.all_inside || status.reject_now
                        || (moves_reg == MOVE_W'(MOVE_LIMIT));
    assign div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            moves_reg   <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            moves_reg   <= moves_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = check_done ? ST_FINISH : ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        moves_next   = moves_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.load   = s_valid;
                moves_next = '0;
            end
            ST_CHECK: begin
                cmd.setup = !check_done;
                if (!check_done) begin
                    moves_next = moves_reg + MOVE_W'(1);
                end
            end
            ST_MUL: begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_FINISH: begin
                cmd.finish = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/lswc_dpath.sv =====
// ----------------------------------------------------------------------------
// lswc_dpath
// Endpoint registers, region codes, intersection multiply, radix-4 restoring
// divider, saturating update and result register.
// ----------------------------------------------------------------------------
module lswc_dpath import lswc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    cmd,
    output status_t status,
    input  window_t win,
    input  coord_t  s_start_x,
    input  coord_t  s_start_y,
    input  coord_t  s_end_x,
    input  coord_t  s_end_y,
    output logic    m_valid,
    input  logic    m_ready,
    output logic    m_visible,
    output coord_t  m_clipped_start_x,
    output coord_t  m_clipped_start_y,
    output coord_t  m_clipped_end_x,
    output coord_t  m_clipped_end_y
);

    typedef logic signed [COORD_W:0] diff_t;

    coord_t sx_reg, sy_reg, ex_reg, ey_reg;
    code_t  c0, c1, csel;

    logic   sel_start_reg, fix_y_reg, neg_reg, den_zero_reg;
    coord_t edge_reg, base_reg;
    mag_t   num_mag_reg, t_mag_reg, den_mag_reg;
    prod_t  quo_reg, quo_next;
    mag_t   rem_reg, rem_next;

    diff_t  dx, dy, num_val, t_val, den_val;
    coord_t edge_val, base_val;
    logic   fix_y_val;

    logic signed [SUM_W-1:0] sum_val;
    prod_t  q_eff;
    coord_t sat_val;

    logic   m_valid_reg;
    logic   visible_reg;
    coord_t out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;

    function automatic mag_t abs_diff(diff_t v);
        diff_t a;
        a = v[COORD_W] ? -v : v;
        return a[COORD_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] base_val_ext(coord_t b);
        return SUM_W'(b);
    endfunction

    assign c0 = region(sx_reg, sy_reg, win);
    assign c1 = region(ex_reg, ey_reg, win);
    assign csel = (c0 != '0) ? c0 : c1;

    assign status.all_inside = ((c0 | c1) == '0);
    assign status.reject_now = ((c0 & c1) != '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign dx = (COORD_W+1)'(ex_reg) - (COORD_W+1)'(sx_reg);
    assign dy = (COORD_W+1)'(ey_reg) - (COORD_W+1)'(sy_reg);

    always_comb begin
        if ((csel & CODE_TOP) != '0) begin
            fix_y_val = 1'b1;
            edge_val  = win.top;
            base_val  = sx_reg;
            num_val   = dx;
            den_val   = dy;
            t_val     = (COORD_W+1)'(win.top) - (COORD_W+1)'(sy_reg);
        end else if ((csel & CODE_BOTTOM) != '0) begin
            fix_y_val = 1'b1;
            edge_val  = win.bottom;
            base_val  = sx_reg;
            num_val   = dx;
            den_val   = dy;
            t_val     = (COORD_W+1)'(win.bottom) - (COORD_W+1)'(sy_reg);
        end else if ((csel & CODE_RIGHT) != '0) begin
            fix_y_val = 1'b0;
            edge_val  = win.right;
            base_val  = sy_reg;
            num_val   = dy;
            den_val   = dx;
            t_val     = (COORD_W+1)'(win.right) - (COORD_W+1)'(sx_reg);
        end else begin
            fix_y_val = 1'b0;
            edge_val  = win.left;
            base_val  = sy_reg;
            num_val   = dy;
            den_val   = dx;
            t_val     = (COORD_W+1)'(win.left) - (COORD_W+1)'(sx_reg);
        end
    end

    // two restoring steps per cycle
    always_comb begin
        logic [COORD_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_RADIX_B; i++) begin
            trial    = {rem_next, quo_next[PROD_W-1]};
            quo_next = {quo_next[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_mag_reg}) begin
                trial       = trial - {1'b0, den_mag_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[COORD_W-1:0];
        end
    end

    assign q_eff   = den_zero_reg ? '0 : quo_reg;
    assign sum_val = neg_reg ? (SUM_W'(base_val_ext(base_reg)) - $signed({2'b00, q_eff}))
                             : (SUM_W'(base_val_ext(base_reg)) + $signed({2'b00, q_eff}));

    always_comb begin
        if (sum_val > SUM_W'(COORD_MAX)) begin
            sat_val = COORD_MAX;
        end else if (sum_val < SUM_W'(COORD_MIN)) begin
            sat_val = COORD_MIN;
        end else begin
            sat_val = sum_val[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg <= s_start_x;
            sy_reg <= s_start_y;
            ex_reg <= s_end_x;
            ey_reg <= s_end_y;
        end else if (cmd.update) begin
            if (sel_start_reg) begin
                sx_reg <= fix_y_reg ? sat_val : edge_reg;
                sy_reg <= fix_y_reg ? edge_reg : sat_val;
            end else begin
                ex_reg <= fix_y_reg ? sat_val : edge_reg;
                ey_reg <= fix_y_reg ? edge_reg : sat_val;
            end
        end
        if (cmd.setup) begin
            sel_start_reg <= (c0 != '0);
            fix_y_reg     <= fix_y_val;
            edge_reg      <= edge_val;
            base_reg      <= base_val;
            neg_reg       <= num_val[COORD_W] ^ t_val[COORD_W] ^ den_val[COORD_W];
            den_zero_reg  <= (den_val == '0);
            num_mag_reg   <= abs_diff(num_val);
            t_mag_reg     <= abs_diff(t_val);
            den_mag_reg   <= abs_diff(den_val);
        end
        if (cmd.mul) begin
            quo_reg <= PROD_W'(num_mag_reg) * PROD_W'(t_mag_reg);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.finish) begin
            visible_reg <= status.all_inside;
            out_sx_reg  <= status.all_inside ? sx_reg : '0;
            out_sy_reg  <= status.all_inside ? sy_reg : '0;
            out_ex_reg  <= status.all_inside ? ex_reg : '0;
            out_ey_reg  <= status.all_inside ? ey_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_visible         = visible_reg;
    assign m_clipped_start_x = out_sx_reg;
    assign m_clipped_start_y = out_sy_reg;
    assign m_clipped_end_x   = out_ex_reg;
    assign m_clipped_end_y   = out_ey_reg;

endmodule
